// ===== rtl/ctr_pkg.sv =====
// Package for the console terminal registers block.
// Holds field widths, item kind codes, bus addresses and the result struct.
// No dependencies.
package ctr_pkg;

  localparam int KindW  = 2;
  localparam int AddrW  = 18;
  localparam int DataW  = 16;
  localparam int ByteW  = 8;
  localparam int CharW  = 7;
  localparam int DelayW = 6;

  // item kinds
  localparam logic [KindW-1:0] KIND_READ  = 2'd0;
  localparam logic [KindW-1:0] KIND_WRITE = 2'd1;
  localparam logic [KindW-1:0] KIND_RX    = 2'd2;
  localparam logic [KindW-1:0] KIND_TICK  = 2'd3;

  // decoded word addresses
  localparam logic [AddrW-1:0] ADDR_KSTAT = 18'o777560;
  localparam logic [AddrW-1:0] ADDR_KBUF  = 18'o777562;
  localparam logic [AddrW-1:0] ADDR_PSTAT = 18'o777564;
  localparam logic [AddrW-1:0] ADDR_PBUF  = 18'o777566;

  // status word bit positions
  localparam int FlagBit = 7;
  localparam int IeBit   = 6;

  // keyboard translations
  localparam logic [ByteW-1:0] RX_STAR_IN  = 8'd42;
  localparam logic [ByteW-1:0] RX_STAR_OUT = 8'd4;
  localparam logic [ByteW-1:0] RX_XOFF_IN  = 8'd19;
  localparam logic [ByteW-1:0] RX_XOFF_OUT = 8'o034;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             bad_address;
    logic             tx_valid;
    logic [CharW-1:0] tx_char;
    logic             rx_irq;
    logic             tx_irq;
  } ctr_result_t;

endpackage

// ===== rtl/ctr_in_if.sv =====
// Input channel interface of the console terminal registers block.
// Depends on ctr_pkg for field widths.
interface ctr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ctr_pkg::KindW-1:0]   kind;
  logic [ctr_pkg::AddrW-1:0]   address;
  logic [ctr_pkg::DataW-1:0]   write_data;
  logic [ctr_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, kind, address, write_data, rx_byte, input ready);
  modport sink   (input valid, kind, address, write_data, rx_byte, output ready);
endinterface

// ===== rtl/ctr_out_if.sv =====
// Result channel interface of the console terminal registers block.
// Depends on ctr_pkg for field widths.
interface ctr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ctr_pkg::DataW-1:0]   read_data;
  logic                        bad_address;
  logic                        tx_valid;
  logic [ctr_pkg::CharW-1:0]   tx_char;
  logic                        rx_irq;
  logic                        tx_irq;

  modport source (output valid, read_data, bad_address, tx_valid, tx_char, rx_irq, tx_irq,
                  input ready);
  modport sink   (input valid, read_data, bad_address, tx_valid, tx_char, rx_irq, tx_irq,
                  output ready);
endinterface

// ===== rtl/console_terminal_registers_top.sv =====
// Console terminal registers: keyboard and printer register pairs on a bus.
// Depends on ctr_pkg, ctr_in_if and ctr_out_if.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    kind, address, write_data, rx_byte
//  out_ch    out  valid/ready    read_data, bad_address, tx_valid, tx_char, rx_irq, tx_irq
//
// One item per clock while in_ch.ready is high; each item gives one registered result.
// Decode and flag updates are one level of logic into the state and result registers.
// A two-entry output stage (result register plus skid) keeps input ready while one
// result waits; input stalls only when both entries are full.
// Synchronous active-low reset: printer ready, all other flags and counts cleared.
module console_terminal_registers_top #(
  parameter int TX_DELAY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  ctr_in_if.sink           in_ch,
  ctr_out_if.source        out_ch
);

  logic                          kbd_done_r, kbd_done_nxt;
  logic                          kbd_ie_r, kbd_ie_nxt;
  logic [ctr_pkg::ByteW-1:0]     kbd_buf_r, kbd_buf_nxt;
  logic                          prn_ready_r, prn_ready_nxt;
  logic                          prn_ie_r, prn_ie_nxt;
  logic [ctr_pkg::ByteW-1:0]     prn_buf_r, prn_buf_nxt;
  logic [ctr_pkg::DelayW-1:0]    delay_r, delay_nxt, delay_inc;

  ctr_pkg::ctr_result_t          res;
  ctr_pkg::ctr_result_t          out_r, skid_r;
  logic                          out_valid_r, skid_valid_r;
  logic                          in_fire, out_fire;

  localparam logic [ctr_pkg::DelayW-1:0] DelayLimit = TX_DELAY[ctr_pkg::DelayW-1:0];

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && !skid_valid_r;
  assign out_fire    = out_valid_r && out_ch.ready;
  assign delay_inc   = delay_r + 1'b1;

  always_comb begin
    kbd_done_nxt  = kbd_done_r;
    kbd_ie_nxt    = kbd_ie_r;
    kbd_buf_nxt   = kbd_buf_r;
    prn_ready_nxt = prn_ready_r;
    prn_ie_nxt    = prn_ie_r;
    prn_buf_nxt   = prn_buf_r;
    delay_nxt     = delay_r;
    res           = '0;
    case (in_ch.kind)
      ctr_pkg::KIND_READ: begin
        if (in_ch.address == ctr_pkg::ADDR_KSTAT) begin
          res.read_data[ctr_pkg::FlagBit] = kbd_done_r;
          res.read_data[ctr_pkg::IeBit]   = kbd_ie_r;
        end else if (in_ch.address == ctr_pkg::ADDR_KBUF) begin
          if (kbd_done_r) begin
            kbd_done_nxt  = 1'b0;
            res.read_data = {{(ctr_pkg::DataW-ctr_pkg::ByteW){1'b0}}, kbd_buf_r};
          end
        end else if (in_ch.address == ctr_pkg::ADDR_PSTAT) begin
          res.read_data[ctr_pkg::FlagBit] = prn_ready_r;
          res.read_data[ctr_pkg::IeBit]   = prn_ie_r;
        end else if (in_ch.address != ctr_pkg::ADDR_PBUF) begin
          res.bad_address = 1'b1;
        end
      end
      ctr_pkg::KIND_WRITE: begin
        if (in_ch.address == ctr_pkg::ADDR_KSTAT) begin
          kbd_ie_nxt = in_ch.write_data[ctr_pkg::IeBit];
        end else if (in_ch.address == ctr_pkg::ADDR_PSTAT) begin
          prn_ie_nxt = in_ch.write_data[ctr_pkg::IeBit];
        end else if (in_ch.address == ctr_pkg::ADDR_PBUF) begin
          prn_buf_nxt   = in_ch.write_data[ctr_pkg::ByteW-1:0];
          prn_ready_nxt = 1'b0;
          delay_nxt     = '0;
        end else begin
          res.bad_address = 1'b1;
        end
      end
      ctr_pkg::KIND_RX: begin
        if (in_ch.rx_byte == ctr_pkg::RX_STAR_IN) begin
          kbd_buf_nxt = ctr_pkg::RX_STAR_OUT;
        end else if (in_ch.rx_byte == ctr_pkg::RX_XOFF_IN) begin
          kbd_buf_nxt = ctr_pkg::RX_XOFF_OUT;
        end else begin
          kbd_buf_nxt = in_ch.rx_byte;
        end
        kbd_done_nxt = 1'b1;
        res.rx_irq   = kbd_ie_r;
      end
      default: begin
        // tick: count runs only while a character is pending
        if (!prn_ready_r) begin
          delay_nxt = delay_inc;
          if (delay_inc > DelayLimit) begin
            res.tx_valid  = 1'b1;
            res.tx_char   = prn_buf_r[ctr_pkg::CharW-1:0];
            prn_ready_nxt = 1'b1;
            res.tx_irq    = prn_ie_r;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbd_done_r  <= 1'b0;
      kbd_ie_r    <= 1'b0;
      kbd_buf_r   <= '0;
      prn_ready_r <= 1'b1;
      prn_ie_r    <= 1'b0;
      prn_buf_r   <= '0;
      delay_r     <= '0;
    end else if (in_fire) begin
      kbd_done_r  <= kbd_done_nxt;
      kbd_ie_r    <= kbd_ie_nxt;
      kbd_buf_r   <= kbd_buf_nxt;
      prn_ready_r <= prn_ready_nxt;
      prn_ie_r    <= prn_ie_nxt;
      prn_buf_r   <= prn_buf_nxt;
      delay_r     <= delay_nxt;
    end
  end

  // output stage: result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_r.read_data;
  assign out_ch.bad_address = out_r.bad_address;
  assign out_ch.tx_valid    = out_r.tx_valid;
  assign out_ch.tx_char     = out_r.tx_char;
  assign out_ch.rx_irq      = out_r.rx_irq;
  assign out_ch.tx_irq      = out_r.tx_irq;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in front");

  a_tx_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.tx_valid) |=> prn_ready_r)
    else $error("printer not ready after character emitted");

  a_bad_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res.bad_address |-> (res.read_data == '0 && !res.tx_valid && !res.rx_irq))
    else $error("undecoded access produced data or events");

  a_kbuf_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.kind == ctr_pkg::KIND_READ && in_ch.address == ctr_pkg::ADDR_KBUF
     && kbd_done_r) |=> !kbd_done_r)
    else $error("keyboard done not cleared by buffer read");

  a_pbuf_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.kind == ctr_pkg::KIND_WRITE && in_ch.address == ctr_pkg::ADDR_PBUF)
    |=> (!prn_ready_r && delay_r == '0))
    else $error("printer buffer write did not restart the delay");

endmodule
